// File: hdl/ssa_pkg.sv
// Shared types, widths and codes for the slab slot allocator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package ssa_pkg;

    // Geometry limits. SLOTS_MAX is a power of two, so a free-stack address
    // is the page index concatenated with the stack position.
    localparam int MAX_PAGES      = 16;
    localparam int SLOTS_MAX      = 64;
    localparam int ALIGN_BYTES    = 16;
    localparam int MIN_SLOT_BYTES = 8;

    localparam int PAGE_W      = $clog2(MAX_PAGES);
    localparam int SLOT_W      = $clog2(SLOTS_MAX);
    localparam int CNT_W       = $clog2(SLOTS_MAX + 1);
    localparam int PCNT_W      = $clog2(MAX_PAGES + 1);
    localparam int TOT_W       = 11;
    localparam int ADDR_W      = PAGE_W + SLOT_W;
    localparam int STACK_DEPTH = MAX_PAGES * SLOTS_MAX;
    localparam int SPP_W       = 7;
    localparam int OBJ_W       = 13;
    localparam int SIZE_W      = 14;
    localparam int PROD_W      = SLOT_W + SIZE_W;
    localparam int OFF_W       = 18;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;

    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DESTROY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LIMIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_PAGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_BYTES   = 1'b1;

    localparam logic [SPP_W-1:0] SPP_RESET = 7'd64;
    localparam logic [OBJ_W-1:0] OBJ_RESET = 13'd16;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_LIMIT,
        OP_FREE,
        OP_DESTROY,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [PAGE_W-1:0] page_index;
        logic [SLOT_W-1:0] slot_index;
    } t_req_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   out_page;
        logic [SLOT_W-1:0]   out_slot;
        logic [OFF_W-1:0]    slot_offset;
        logic [CNT_W-1:0]    page_in_use;
        logic [TOT_W-1:0]    total_in_use;
    } t_res_item;

    typedef struct packed {
        logic              en;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] pos;
        logic              fresh;
    } t_stack_rd;

    typedef struct packed {
        logic              en;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] pos;
        logic [SLOT_W-1:0] data;
    } t_stack_wr;

    typedef struct packed {
        logic              en;
        logic [PAGE_W-1:0] page;
        logic              zero;
    } t_map_rd;

    typedef struct packed {
        logic              en;
        logic [PAGE_W-1:0] page;
        logic              set;
    } t_map_wr;

    // Slots per page as used: zero acts as one, large values saturate.
    function automatic logic [CNT_W-1:0] eff_slots(input logic [SPP_W-1:0] n);
        logic [CNT_W-1:0] r;
        r = CNT_W'(n);
        if (n == '0) begin
            r = CNT_W'(1);
        end else if (CNT_W'(n) > CNT_W'(SLOTS_MAX)) begin
            r = CNT_W'(SLOTS_MAX);
        end
        return r;
    endfunction

    // Slot size: raised to the minimum, then rounded up to the alignment,
    // which is a power of two.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [OBJ_W-1:0] ob);
        logic [SIZE_W-1:0] s;
        s = SIZE_W'(ob);
        if (s < SIZE_W'(MIN_SLOT_BYTES)) begin
            s = SIZE_W'(MIN_SLOT_BYTES);
        end
        s = s + SIZE_W'(ALIGN_BYTES - 1);
        return s & ~SIZE_W'(ALIGN_BYTES - 1);
    endfunction

endpackage

// File: hdl/ssa_free_stack.sv
// Free-slot stack memory of all pages, one synchronous read and one write port.
// Depends on ssa_pkg. Untouched positions of a fresh page read as their own index.
`timescale 1ns / 1ps

module ssa_free_stack (
    input  logic                      i_clk,
    input  ssa_pkg::t_stack_rd        i_rd,
    input  ssa_pkg::t_stack_wr        i_wr,
    output logic [ssa_pkg::SLOT_W-1:0] o_slot
);
    import ssa_pkg::*;

    logic [SLOT_W-1:0] r_mem [STACK_DEPTH];
    logic [SLOT_W-1:0] r_rdata;
    logic [SLOT_W-1:0] r_pos;
    logic              r_fresh;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.page, i_wr.pos}] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rdata <= r_mem[{i_rd.page, i_rd.pos}];
            r_pos   <= i_rd.pos;
            r_fresh <= i_rd.fresh;
        end
    end

    // A position below the page's high-water mark was never pushed since the
    // page was created, so it still holds the identity value.
    assign o_slot = r_fresh ? r_pos : r_rdata;

endmodule

// File: hdl/ssa_slot_map.sv
// Allocation bitmap, one row of slot bits per page in a synchronous memory.
// Depends on ssa_pkg. Tests one bit of the row read and writes it back modified.
`timescale 1ns / 1ps

module ssa_slot_map (
    input  logic                       i_clk,
    input  ssa_pkg::t_map_rd           i_rd,
    input  ssa_pkg::t_map_wr           i_wr,
    input  logic [ssa_pkg::SLOT_W-1:0] i_slot,
    output logic                       o_bit
);
    import ssa_pkg::*;

    logic [SLOTS_MAX-1:0] r_mem [MAX_PAGES];
    logic [SLOTS_MAX-1:0] r_row;
    logic                 r_zero;
    logic [SLOTS_MAX-1:0] w_row;
    logic [SLOTS_MAX-1:0] w_mask;

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_row  <= r_mem[i_rd.page];
            r_zero <= i_rd.zero;
        end
    end

    // A page being created starts from an empty row.
    assign w_row  = r_zero ? '0 : r_row;
    assign w_mask = {{(SLOTS_MAX - 1){1'b0}}, 1'b1} << i_slot;
    assign o_bit  = w_row[i_slot];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.page] <= i_wr.set ? (w_row | w_mask) : (w_row & ~w_mask);
        end
    end

endmodule

// File: hdl/ssa_ctrl.sv
// Request sequencer: page search, counters, geometry latch and result register.
// Depends on ssa_pkg; drives the free-stack and slot-map memories.
`timescale 1ns / 1ps

module ssa_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ssa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ssa_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ssa_pkg::t_req_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ssa_pkg::t_res_item            o_out_data,
    output ssa_pkg::t_stack_rd            o_stack_rd,
    output ssa_pkg::t_stack_wr            o_stack_wr,
    input  logic [ssa_pkg::SLOT_W-1:0]    i_stack_slot,
    output ssa_pkg::t_map_rd              o_map_rd,
    output ssa_pkg::t_map_wr              o_map_wr,
    output logic [ssa_pkg::SLOT_W-1:0]    o_map_slot,
    input  logic                          i_map_bit
);
    import ssa_pkg::*;

    t_state r_state, n_state;

    logic [SPP_W-1:0]  r_spp;
    logic [OBJ_W-1:0]  r_ob;
    logic [CNT_W-1:0]  r_geo_slots;
    logic [SIZE_W-1:0] r_geo_size;
    logic [PCNT_W-1:0] r_pages;
    logic [CNT_W-1:0]  r_used [MAX_PAGES];
    logic [CNT_W-1:0]  r_maxu [MAX_PAGES];
    logic [TOT_W-1:0]  r_total;

    t_op               r_op, n_op;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic              r_new, n_new;
    logic              r_fresh, n_fresh;
    logic              r_pre_ok, n_pre_ok;
    logic              r_pvalid, n_pvalid;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic              r_out_valid;
    t_res_item         r_out, n_res;

    logic              w_accept;
    logic              w_go;
    logic [CNT_W-1:0]  w_geo;
    logic              w_found;
    logic [PAGE_W-1:0] w_found_idx;
    logic [SLOT_W-1:0] w_slot_exec;
    logic              w_free_ok;
    logic [CNT_W-1:0]  w_cnt_inc;
    logic [CNT_W-1:0]  w_cnt_dec;
    logic [TOT_W-1:0]  w_tot_inc;
    logic [TOT_W-1:0]  w_tot_dec;
    logic [PROD_W-1:0] w_prod;

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_accept   = 1'b0;
        w_go       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                w_accept   = i_in_valid;
            end
            S_EXEC: begin
                w_go = !r_out_valid || !i_out_stall;
            end
        endcase
    end

    // ---------------- request decode and page search ----------------
    assign w_geo = (r_pages == '0) ? eff_slots(r_spp) : r_geo_slots;

    // The newest created page with a free slot wins.
    always_comb begin
        w_found     = 1'b0;
        w_found_idx = '0;
        for (int i = 0; i < MAX_PAGES; i++) begin
            if ((PCNT_W'(i) < r_pages) && (r_used[i] < w_geo)) begin
                w_found     = 1'b1;
                w_found_idx = PAGE_W'(i);
            end
        end
    end

    always_comb begin
        n_op     = OP_NOP;
        n_page   = '0;
        n_new    = 1'b0;
        n_fresh  = 1'b0;
        n_pre_ok = 1'b0;
        n_pvalid = 1'b0;
        n_cnt    = '0;
        n_pos    = '0;
        unique case (i_in_data.req_type)
            REQ_ALLOC: begin
                if (w_found) begin
                    n_op    = OP_ALLOC;
                    n_page  = w_found_idx;
                    n_cnt   = r_used[w_found_idx];
                    n_fresh = (r_used[w_found_idx] == r_maxu[w_found_idx]);
                end else if (r_pages >= PCNT_W'(MAX_PAGES)) begin
                    n_op = OP_LIMIT;
                end else begin
                    n_op    = OP_ALLOC;
                    n_page  = r_pages[PAGE_W-1:0];
                    n_new   = 1'b1;
                    n_fresh = 1'b1;
                end
                n_pos = SLOT_W'(w_geo - n_cnt - CNT_W'(1));
            end
            REQ_FREE: begin
                n_op     = OP_FREE;
                n_page   = i_in_data.page_index;
                n_cnt    = r_used[i_in_data.page_index];
                n_pvalid = PCNT_W'(i_in_data.page_index) < r_pages;
                n_pre_ok = n_pvalid && (CNT_W'(i_in_data.slot_index) < r_geo_slots)
                           && (n_cnt != '0);
                n_pos    = SLOT_W'(r_geo_slots - n_cnt);
            end
            REQ_DESTROY: begin
                n_op = OP_DESTROY;
            end
            default: begin
                n_op = OP_NOP;
            end
        endcase
    end

    assign o_stack_rd.en    = w_accept && (n_op == OP_ALLOC);
    assign o_stack_rd.page  = n_page;
    assign o_stack_rd.pos   = n_pos;
    assign o_stack_rd.fresh = n_fresh;

    assign o_map_rd.en   = w_accept && ((n_op == OP_ALLOC) || (n_op == OP_FREE));
    assign o_map_rd.page = n_page;
    assign o_map_rd.zero = n_new;

    // ---------------- execute ----------------
    assign w_slot_exec = (r_op == OP_ALLOC) ? i_stack_slot : r_slot;
    assign o_map_slot  = w_slot_exec;
    assign w_free_ok   = r_pre_ok && i_map_bit;
    assign w_cnt_inc   = r_cnt + CNT_W'(1);
    assign w_cnt_dec   = r_cnt - CNT_W'(1);
    assign w_tot_inc   = r_total + TOT_W'(1);
    assign w_tot_dec   = (r_total != '0) ? (r_total - TOT_W'(1)) : r_total;
    assign w_prod      = PROD_W'(w_slot_exec) * PROD_W'(r_geo_size);

    assign o_stack_wr.en   = w_go && (r_op == OP_FREE) && w_free_ok;
    assign o_stack_wr.page = r_page;
    assign o_stack_wr.pos  = r_pos;
    assign o_stack_wr.data = r_slot;

    assign o_map_wr.en   = w_go && ((r_op == OP_ALLOC) || ((r_op == OP_FREE) && w_free_ok));
    assign o_map_wr.page = r_page;
    assign o_map_wr.set  = (r_op == OP_ALLOC);

    always_comb begin
        n_res              = '0;
        n_res.status       = ST_OK;
        n_res.total_in_use = r_total;
        unique case (r_op)
            OP_ALLOC: begin
                n_res.out_page     = r_page;
                n_res.out_slot     = w_slot_exec;
                n_res.slot_offset  = w_prod[OFF_W-1:0];
                n_res.page_in_use  = w_cnt_inc;
                n_res.total_in_use = w_tot_inc;
            end
            OP_LIMIT: begin
                n_res.status = ST_LIMIT;
            end
            OP_FREE: begin
                n_res.out_page = r_page;
                n_res.out_slot = r_slot;
                if (w_free_ok) begin
                    n_res.slot_offset  = w_prod[OFF_W-1:0];
                    n_res.page_in_use  = w_cnt_dec;
                    n_res.total_in_use = w_tot_dec;
                end else begin
                    n_res.status      = ST_INVALID;
                    n_res.page_in_use = r_pvalid ? r_cnt : '0;
                end
            end
            OP_DESTROY: begin
                n_res.total_in_use = '0;
            end
            OP_NOP: begin
                n_res.status = ST_OK;
            end
            default: begin
                n_res.status = ST_OK;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_spp       <= SPP_RESET;
            r_ob        <= OBJ_RESET;
            r_geo_slots <= '0;
            r_geo_size  <= '0;
            r_pages     <= '0;
            r_total     <= '0;
            r_op        <= OP_NOP;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_PAGES; i++) begin
                r_used[i] <= '0;
                r_maxu[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SLOTS_PER_PAGE: r_spp <= i_cfg_data[SPP_W-1:0];
                    CFG_OBJECT_BYTES:   r_ob  <= i_cfg_data[OBJ_W-1:0];
                endcase
            end

            if (w_accept) begin
                r_op <= n_op;
                // Geometry is frozen when the first page is created.
                if ((n_op == OP_ALLOC) && (r_pages == '0)) begin
                    r_geo_slots <= eff_slots(r_spp);
                    r_geo_size  <= eff_size(r_ob);
                end
            end

            if (w_go) begin
                priority if (r_op == OP_ALLOC) begin
                    r_used[r_page] <= w_cnt_inc;
                    if (r_fresh) r_maxu[r_page] <= w_cnt_inc;
                    if (r_new) r_pages <= r_pages + PCNT_W'(1);
                    r_total <= w_tot_inc;
                end else if ((r_op == OP_FREE) && w_free_ok) begin
                    r_used[r_page] <= w_cnt_dec;
                    r_total        <= w_tot_dec;
                end else if (r_op == OP_DESTROY) begin
                    r_pages     <= '0;
                    r_total     <= '0;
                    r_geo_slots <= '0;
                    r_geo_size  <= '0;
                    for (int i = 0; i < MAX_PAGES; i++) begin
                        r_used[i] <= '0;
                        r_maxu[i] <= '0;
                    end
                end
            end

            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page   <= n_page;
            r_slot   <= i_in_data.slot_index;
            r_pos    <= n_pos;
            r_new    <= n_new;
            r_fresh  <= n_fresh;
            r_pre_ok <= n_pre_ok;
            r_pvalid <= n_pvalid;
            r_cnt    <= n_cnt;
        end
        if (w_go) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hdl/slab_slot_allocator_top.sv
// Slab slot allocator. The accepting cycle (S_IDLE) issues the free-stack and slot-map
// reads; S_EXEC then updates, writes back and loads the output register once the output
// is not stalled. A new request is taken only after the previous one has left S_EXEC;
// a stalled result holds the next one in execution.
// Synchronous reset clears page counts, totals and the geometry latch at once;
// neither memory needs a clearing pass.
`timescale 1ns / 1ps

module slab_slot_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ssa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ssa_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ssa_pkg::t_req_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ssa_pkg::t_res_item            o_out_data
);
    import ssa_pkg::*;

    t_stack_rd         w_stack_rd;
    t_stack_wr         w_stack_wr;
    logic [SLOT_W-1:0] w_stack_slot;
    t_map_rd           w_map_rd;
    t_map_wr           w_map_wr;
    logic [SLOT_W-1:0] w_map_slot;
    logic              w_map_bit;

    ssa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data),
        .o_stack_rd   (w_stack_rd),
        .o_stack_wr   (w_stack_wr),
        .i_stack_slot (w_stack_slot),
        .o_map_rd     (w_map_rd),
        .o_map_wr     (w_map_wr),
        .o_map_slot   (w_map_slot),
        .i_map_bit    (w_map_bit)
    );

    ssa_free_stack u_free_stack (
        .i_clk  (i_clk),
        .i_rd   (w_stack_rd),
        .i_wr   (w_stack_wr),
        .o_slot (w_stack_slot)
    );

    ssa_slot_map u_slot_map (
        .i_clk  (i_clk),
        .i_rd   (w_map_rd),
        .i_wr   (w_map_wr),
        .i_slot (w_map_slot),
        .o_bit  (w_map_bit)
    );

    // A fresh result only follows a cycle in which a request was being worked on.
    a_result_follows_request: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall)
    ) else $error("result appeared without a request in progress");

    // An accepted request blocks the input in the following cycle.
    a_accept_then_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("input not held off after accepting a request");

    // A push onto a free stack always goes with clearing the slot's map bit.
    a_push_clears_bit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_stack_wr.en |-> (w_map_wr.en && !w_map_wr.set)
    ) else $error("free-stack push without slot map clear");

    // No memory is read while a request is still being executed.
    a_no_read_while_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_stack_rd.en || w_map_rd.en) |=> !(w_stack_rd.en || w_map_rd.en)
    ) else $error("memory read issued during execution");

endmodule

// File: test/slab_slot_allocator_checker.sv
// Checker for the slab slot allocator: follows the config port, the request and the reply
// channels, predicts every reply and compares it field by field.
// Depends on ssa_pkg for the request and reply types, widths and codes.
`timescale 1ns / 1ps

module slab_slot_allocator_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ssa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ssa_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  ssa_pkg::t_req_item            i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  ssa_pkg::t_res_item            i_out_data,
    output int                            o_pending,
    output int                            o_fail_count
);
    import ssa_pkg::*;

    // Register copies and the allocator state as the block should hold it.
    logic [SPP_W-1:0]  reg_spp;
    logic [OBJ_W-1:0]  reg_obj;
    int                pages_made;
    logic [CNT_W-1:0]  page_fill [MAX_PAGES];
    logic [SLOT_W-1:0] free_stack [STACK_DEPTH];
    bit                slot_busy [STACK_DEPTH];
    logic [TOT_W-1:0]  slots_in_use;
    int                geo_slots;
    int                geo_size;

    t_res_item outcomes_due [$];
    int        replies_seen;
    int        fail_count;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] reply %0d: %s", $realtime, replies_seen, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0d, should be %0d", name, got, want));
        end
    endtask

    function automatic void wipe_pages();
        pages_made   = 0;
        slots_in_use = '0;
        geo_slots    = 0;
        geo_size     = 0;
        for (int p = 0; p < MAX_PAGES; p++) begin
            page_fill[p] = '0;
        end
        for (int a = 0; a < STACK_DEPTH; a++) begin
            slot_busy[a] = 1'b0;
        end
    endfunction

    // Applies one request to the state and returns the reply it must produce.
    function automatic t_res_item slab_outcome(input t_req_item rq);
        t_res_item r;
        int        pg;
        int        sl;
        int        pos;
        int        base;
        r  = '0;
        pg = -1;
        case (rq.req_type)
            REQ_ALLOC: begin
                // Geometry is latched when the first page is made.
                if (pages_made == 0) begin
                    geo_slots = (reg_spp == '0) ? 1 :
                                (int'(reg_spp) > SLOTS_MAX) ? SLOTS_MAX : int'(reg_spp);
                    geo_size  = (int'(reg_obj) < MIN_SLOT_BYTES) ? MIN_SLOT_BYTES
                                                                 : int'(reg_obj);
                    geo_size  = ((geo_size + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
                end
                for (int i = pages_made - 1; i >= 0 && pg < 0; i--) begin
                    if (int'(page_fill[i]) < geo_slots) begin
                        pg = i;
                    end
                end
                if (pg < 0 && pages_made >= MAX_PAGES) begin
                    r.status       = ST_LIMIT;
                    r.total_in_use = slots_in_use;
                end else begin
                    if (pg < 0) begin
                        pg = pages_made;
                        pages_made++;
                        page_fill[pg] = '0;
                        for (int i = 0; i < geo_slots; i++) begin
                            free_stack[pg * SLOTS_MAX + i] = SLOT_W'(i);
                            slot_busy[pg * SLOTS_MAX + i]  = 1'b0;
                        end
                    end
                    base = pg * SLOTS_MAX;
                    pos  = geo_slots - int'(page_fill[pg]) - 1;
                    sl   = int'(free_stack[base + pos]);
                    slot_busy[base + sl] = 1'b1;
                    page_fill[pg]++;
                    slots_in_use++;
                    r.status       = ST_OK;
                    r.out_page     = PAGE_W'(pg);
                    r.out_slot     = SLOT_W'(sl);
                    r.slot_offset  = OFF_W'(sl * geo_size);
                    r.page_in_use  = page_fill[pg];
                    r.total_in_use = slots_in_use;
                end
            end
            REQ_FREE: begin
                pg   = int'(rq.page_index);
                sl   = int'(rq.slot_index);
                base = pg * SLOTS_MAX;
                r.out_page     = rq.page_index;
                r.out_slot     = rq.slot_index;
                r.total_in_use = slots_in_use;
                if (pg >= pages_made) begin
                    r.status = ST_INVALID;
                end else if (sl >= geo_slots || !slot_busy[base + sl] ||
                             page_fill[pg] == '0) begin
                    r.status      = ST_INVALID;
                    r.page_in_use = page_fill[pg];
                end else begin
                    pos = geo_slots - int'(page_fill[pg]);
                    free_stack[base + pos] = SLOT_W'(sl);
                    slot_busy[base + sl]   = 1'b0;
                    page_fill[pg]--;
                    if (slots_in_use != '0) begin
                        slots_in_use--;
                    end
                    r.status       = ST_OK;
                    r.slot_offset  = OFF_W'(sl * geo_size);
                    r.page_in_use  = page_fill[pg];
                    r.total_in_use = slots_in_use;
                end
            end
            REQ_DESTROY: begin
                wipe_pages();
            end
            default: begin
                // An unknown request changes nothing and reports the total.
                r.total_in_use = slots_in_use;
            end
        endcase
        return r;
    endfunction

    initial begin
        fail_count   = 0;
        replies_seen = 0;
        reg_spp      = SPP_RESET;
        reg_obj      = OBJ_RESET;
        wipe_pages();
    end

    always @(posedge i_clk) begin : watch
        t_res_item want;
        t_res_item got;
        if (!i_rst_n) begin
            reg_spp = SPP_RESET;
            reg_obj = OBJ_RESET;
            wipe_pages();
            outcomes_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SLOTS_PER_PAGE) begin
                    reg_spp = i_cfg_data[SPP_W-1:0];
                end else if (i_cfg_idx == CFG_OBJECT_BYTES) begin
                    reg_obj = i_cfg_data[OBJ_W-1:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                outcomes_due.push_back(slab_outcome(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (outcomes_due.size() == 0) begin
                    report_mismatch("reply arrived with no request outstanding");
                end else begin
                    want = outcomes_due.pop_front();
                    check_field("status", got.status, want.status);
                    check_field("out_page", got.out_page, want.out_page);
                    check_field("out_slot", got.out_slot, want.out_slot);
                    check_field("slot_offset", got.slot_offset, want.slot_offset);
                    check_field("page_in_use", got.page_in_use, want.page_in_use);
                    check_field("total_in_use", got.total_in_use, want.total_in_use);
                    if ($isunknown(got)) begin
                        report_mismatch("reply carries unknown bits");
                    end
                end
                replies_seen++;
            end
        end
        o_pending <= outcomes_due.size();
    end

endmodule

// File: test/tb_slab_slot_allocator_top.sv
// Testbench top for the slab slot allocator: clock, reset, register writes and
// request traffic with random gaps and stalls. Needs ssa_pkg, the block and
// slab_slot_allocator_checker, which predicts and compares every reply.
`timescale 1ns / 1ps

module tb_slab_slot_allocator_top;
    import ssa_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int LONG_HOLD = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    logic                 req_valid;
    logic                 req_stall;
    t_req_item            req_item;
    logic                 res_valid;
    logic                 res_stall;
    t_res_item            res_item;
    int                   pending;
    int                   fails;

    // Stimulus shaping: burst switches and a rough idea of what is allocated.
    bit gaps_on;
    bit hold_wanted;
    bit hold_done;
    int live_est;
    int spp_est;

    slab_slot_allocator_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_item),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_data  (res_item)
    );

    slab_slot_allocator_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (req_valid),
        .i_in_stall   (req_stall),
        .i_in_data    (req_item),
        .i_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .i_out_data   (res_item),
        .o_pending    (pending),
        .o_fail_count (fails)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send(input logic [REQ_W-1:0] kind, input int pg, input int sl);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= '{req_type: kind, page_index: PAGE_W'(pg), slot_index: SLOT_W'(sl)};
        do @(posedge clk); while (req_stall);
    endtask

    // Waits until every request sent so far has its reply.
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_geometry(input int spp, input int obj);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SLOTS_PER_PAGE;
        cfg_data <= CFG_W'(spp);
        @(posedge clk);
        cfg_idx  <= CFG_OBJECT_BYTES;
        cfg_data <= CFG_W'(obj);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Mostly allocs and frees of slots that are likely held, plus some noise.
    // Without a destroy at the start the old geometry stays latched.
    task automatic random_phase(input int spp, input int obj, input int count);
        int unsigned roll;
        int          pages_est;
        int          pg;
        int          sl;
        settle();
        set_geometry(spp, obj);
        if ($urandom_range(0, 2) != 0 || live_est == 0) begin
            send(REQ_DESTROY, $urandom_range(0, 15), $urandom_range(0, 63));
            live_est = 0;
            spp_est  = (spp == 0) ? 1 : (spp > SLOTS_MAX) ? SLOTS_MAX : spp;
        end
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 39) == 0) begin
                gaps_on = !gaps_on;
            end
            roll = $urandom_range(0, 99);
            if (roll < 48) begin
                send(REQ_ALLOC, $urandom_range(0, 15), $urandom_range(0, 63));
                live_est++;
            end else if (roll < 88) begin
                pages_est = live_est / spp_est + 1;
                if (pages_est > MAX_PAGES) begin
                    pages_est = MAX_PAGES;
                end
                pg = $urandom_range(0, pages_est - 1);
                sl = spp_est - 1 - int'($urandom_range(0, (spp_est - 1) / 2));
                send(REQ_FREE, pg, sl);
                if (live_est > 0) begin
                    live_est--;
                end
            end else if (roll < 94) begin
                send(REQ_FREE, $urandom_range(0, 15), $urandom_range(0, 63));
            end else if (roll < 97) begin
                send(REQ_DESTROY, $urandom_range(0, 15), $urandom_range(0, 63));
                live_est = 0;
                spp_est  = (spp == 0) ? 1 : (spp > SLOTS_MAX) ? SLOTS_MAX : spp;
            end else begin
                send(REQ_UNUSED, $urandom_range(0, 15), $urandom_range(0, 63));
            end
        end
    endtask

    // Reply side: random stalls per reply, bursts without stalls, and one long
    // hold so the block backs up and stalls incoming requests.
    initial begin : drain
        int unsigned pause;
        bit          stalls_on;
        stalls_on = 1'b1;
        res_stall <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_wanted && !hold_done) begin
                hold_done = 1'b1;
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                if ($urandom_range(0, 39) == 0) begin
                    stalls_on = !stalls_on;
                end
                pause = stalls_on ? $urandom_range(0, 14) : 0;
                if (pause != 0) begin
                    res_stall <= 1'b1;
                    repeat (pause) @(posedge clk);
                end
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    initial begin : stimulus
        int waited;
        gaps_on     = 1'b1;
        hold_wanted = 1'b0;
        hold_done   = 1'b0;
        live_est    = 0;
        spp_est     = SLOTS_MAX;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_idx   <= CFG_SLOTS_PER_PAGE;
        cfg_data  <= '0;
        req_valid <= 1'b0;
        req_item  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty allocator, unknown request, LIFO reuse and double free.
        send(REQ_FREE, 0, 0);
        send(REQ_DESTROY, 15, 63);
        send(REQ_UNUSED, 15, 63);
        send(REQ_ALLOC, 0, 0);
        send(REQ_ALLOC, 15, 63);
        send(REQ_FREE, 0, 62);
        send(REQ_FREE, 0, 62);
        send(REQ_FREE, 15, 63);
        send(REQ_ALLOC, 0, 0);
        settle();

        // One slot per page: fill all pages, hit the page limit, then free a
        // slot index that lies beyond the page.
        set_geometry(1, 4096);
        send(REQ_DESTROY, 0, 0);
        for (int i = 0; i < MAX_PAGES + 1; i++) begin
            send(REQ_ALLOC, 0, 0);
        end
        send(REQ_FREE, 3, 1);
        live_est = MAX_PAGES;
        spp_est  = 1;

        random_phase(64, 16, 100);
        random_phase(1, 1, 90);
        hold_wanted = 1'b1;
        random_phase(64, 8191, 110);
        random_phase(0, 4096, 80);
        random_phase(127, 4, 100);
        random_phase(2, 4096, 90);
        random_phase(7, 33, 90);
        random_phase($urandom_range(1, 64), $urandom_range(1, 4096), 100);
        random_phase(3, 8, 80);

        req_valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (pending != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (fails == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
